### rtl/lz77_triple_decoder_defines.svh
// assertion macros used by the checker
`ifndef LZ77_TRIPLE_DECODER_DEFINES_SVH
`define LZ77_TRIPLE_DECODER_DEFINES_SVH

// same-cycle implication, quiet while reset is high
`define LZD_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define LZD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/lzd_pkg.sv
package lzd_pkg;

   // field widths
   localparam int DIST_W = 13;
   localparam int LEN_W  = 6;
   localparam int BYTE_W = 8;

   // largest distance code the input can carry
   localparam int DIST_MAX = 8191;

   // width of the modulo step counter
   localparam int STEP_W = 4;

   // history write request
   typedef struct packed {
      logic              en;
      logic [BYTE_W-1:0] data;
   } hist_wr_type;

   // sequencer states
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_MOD  = 6'b000010,
      ST_SRC  = 6'b000100,
      ST_READ = 6'b001000,
      ST_WAIT = 6'b010000,
      ST_LIT  = 6'b100000
   } state_type;

endpackage

### rtl/lz77_triple_decoder.sv
// LZ77 triple decoder. Each accepted transaction (distance, length, literal)
// produces length bytes copied from the decoded history at that distance back,
// then the literal with rsp_last set; copies may overlap the bytes they make.
// A zero literal ends the stream until reset. The history is a ring of
// WINDOW_DEPTH bytes that reads as zero where nothing was written yet; a write
// pointer and wrap mark track this, so no clearing pass runs after reset.
// Timing: one shared compare-subtract unit first reduces the distance modulo
// the window (one step per cycle, one step at the default window) and then
// forms the source pointer. Each copied byte passes a read state and a wait
// state for the registered history read, then the literal follows; a zero
// length goes straight to the literal. The byte and literal states hold while
// the result side stalls. req_stall stays high while a transaction is in work.
module lz77_triple_decoder
   import lzd_pkg::*;
#(
   parameter int WINDOW_DEPTH = 4096,
   parameter int MATCH_LIMIT  = 63
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DIST_W-1:0] req_copy_distance,
   input  logic [LEN_W-1:0]  req_match_length,
   input  logic [BYTE_W-1:0] req_literal_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [BYTE_W-1:0] rsp_out_byte,
   output logic              rsp_last
);

   // highest shift of the window that still fits under the largest distance
   function automatic int mod_top(int depth);
      int top;
      top = 0;
      for (int i = 0; i < DIST_W; i++) begin
         if ((depth << i) <= DIST_MAX) begin
            top = i;
         end
      end
      return top;
   endfunction

   localparam int AW      = $clog2(WINDOW_DEPTH);
   localparam int UW      = (AW + 1 > DIST_W) ? AW + 1 : DIST_W;
   localparam int MOD_TOP = mod_top(WINDOW_DEPTH);

   state_type         state_ff, state_in;
   logic              stopped_ff, stopped_in;
   logic [DIST_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] lit_ff, lit_in;
   logic [AW-1:0]     src_ff, src_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [UW-1:0]     unit_a;
   logic [UW-1:0]     unit_b;
   logic [UW-1:0]     unit_diff;
   logic              unit_ge;
   logic [UW-1:0]     wrap_sum;
   logic [LEN_W-1:0]  len_sat;
   logic              out_free;
   hist_wr_type       hist_wr;
   logic [AW-1:0]     wr_pos;
   logic [BYTE_W-1:0] rd_data;

   lzd_sub_unit #(
      .UW (UW)
   ) u_sub (
      .a    (unit_a),
      .b    (unit_b),
      .diff (unit_diff),
      .ge   (unit_ge)
   );

   lzd_history #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .AW           (AW)
   ) u_hist (
      .clock   (clock),
      .reset   (reset),
      .wr      (hist_wr),
      .rd_addr (src_ff),
      .wr_pos  (wr_pos),
      .rd_data (rd_data)
   );

   // length saturation and output register availability
   assign len_sat  = (req_match_length > LEN_W'(MATCH_LIMIT)) ?
                     LEN_W'(MATCH_LIMIT) : req_match_length;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign wrap_sum = unit_diff + UW'(WINDOW_DEPTH);
   assign req_stall = (state_ff != ST_IDLE);

   // shared unit operand select
   always_comb begin
      if (state_ff == ST_SRC) begin
         unit_a = UW'(wr_pos);
         unit_b = UW'(rem_ff);
      end else begin
         unit_a = UW'(rem_ff);
         unit_b = UW'(WINDOW_DEPTH) << step_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      stopped_in   = stopped_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      cnt_in       = cnt_ff;
      lit_in       = lit_ff;
      src_in       = src_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      hist_wr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stopped_ff) begin
               if (req_literal_byte == '0) begin
                  stopped_in = 1'b1;
               end else begin
                  rem_in  = req_copy_distance;
                  cnt_in  = len_sat;
                  lit_in  = req_literal_byte;
                  step_in = STEP_W'(MOD_TOP);
                  state_in = (len_sat == '0) ? ST_LIT : ST_MOD;
               end
            end
         end
         // distance modulo window, one restoring step a cycle
         ST_MOD: begin
            if (unit_ge) begin
               rem_in = unit_diff[DIST_W-1:0];
            end
            if (step_ff == '0) begin
               state_in = ST_SRC;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         // source pointer behind the write pointer, wrapped into the ring
         ST_SRC: begin
            src_in   = unit_ge ? unit_diff[AW-1:0] : wrap_sum[AW-1:0];
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_WAIT;
         end
         // copied byte is out of the ring: emit and write it back
         ST_WAIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = rd_data;
               rsp_last_in  = 1'b0;
               hist_wr.en   = 1'b1;
               hist_wr.data = rd_data;
               src_in = (src_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : src_ff + 1'b1;
               cnt_in = cnt_ff - 1'b1;
               state_in = (cnt_ff == LEN_W'(1)) ? ST_LIT : ST_READ;
            end
         end
         ST_LIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = lit_ff;
               rsp_last_in  = 1'b1;
               hist_wr.en   = 1'b1;
               hist_wr.data = lit_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         stopped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         stopped_ff   <= stopped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      cnt_ff      <= cnt_in;
      lit_ff      <= lit_in;
      src_ff      <= src_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

### rtl/lzd_sub_unit.sv
module lzd_sub_unit
   import lzd_pkg::*;
#(
   parameter int UW = 13
) (
   input  logic [UW-1:0] a,
   input  logic [UW-1:0] b,
   output logic [UW-1:0] diff,
   output logic          ge
);

   logic [UW:0] full;

   // shared compare and subtract, borrow gives the compare
   assign full = {1'b0, a} - {1'b0, b};
   assign diff = full[UW-1:0];
   assign ge   = ~full[UW];

endmodule

### rtl/lzd_history.sv
module lzd_history
   import lzd_pkg::*;
#(
   parameter int WINDOW_DEPTH = 4096,
   parameter int AW           = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  hist_wr_type       wr,
   input  logic [AW-1:0]     rd_addr,
   output logic [AW-1:0]     wr_pos,
   output logic [BYTE_W-1:0] rd_data
);

   logic [BYTE_W-1:0] mem [WINDOW_DEPTH];
   logic [BYTE_W-1:0] rd_q_ff;
   logic              rd_hit_ff;
   logic [AW-1:0]     wr_pos_ff;
   logic [AW-1:0]     wr_pos_in;
   logic              wrap_ff;
   logic              wrap_in;

   // ring storage, registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_pos_ff] <= wr.data;
      end
      rd_q_ff   <= mem[rd_addr];
      rd_hit_ff <= wrap_ff || (rd_addr < wr_pos_ff);
   end

   // write pointer and wrap mark: entries past the fill point read as zero
   always_comb begin
      wr_pos_in = wr_pos_ff;
      wrap_in   = wrap_ff;
      if (wr.en) begin
         if (wr_pos_ff == AW'(WINDOW_DEPTH - 1)) begin
            wr_pos_in = '0;
            wrap_in   = 1'b1;
         end else begin
            wr_pos_in = wr_pos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_pos_ff <= '0;
         wrap_ff   <= 1'b0;
      end else begin
         wr_pos_ff <= wr_pos_in;
         wrap_ff   <= wrap_in;
      end
   end

   assign wr_pos  = wr_pos_ff;
   assign rd_data = rd_hit_ff ? rd_q_ff : '0;

endmodule

### rtl/lzd_checker.sv
`include "lz77_triple_decoder_defines.svh"

module lzd_checker
   import lzd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic [BYTE_W-1:0] req_literal_byte,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [BYTE_W-1:0] rsp_out_byte,
   input logic              rsp_last
);

   // a stalled result transaction stays
   `LZD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp dropped")

   // a stalled result byte does not change
   `LZD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_out_byte), "rsp byte moved")

   // a copied byte on the output means the triple is still in work
   `LZD_ASSERT_IMPLY(a_busy_mid_run, clock, reset, rsp_valid && !rsp_last, req_stall, "idle mid run")

   // an end-of-stream transaction makes no output
   `LZD_ASSERT_NEXT(a_end_silent, clock, reset, req_valid && !req_stall && (req_literal_byte == '0) && !rsp_valid, !rsp_valid, "output after end")

endmodule

bind lz77_triple_decoder lzd_checker u_lzd_checker (.*);
